// ----- rtl/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared types, register indexes, command and status structs and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int StepW = $clog2(CORDIC_STEPS + 1);
	localparam logic signed [34:0] CordicGain = 35'sd652032874;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ENC_SCALE   = 3'd0,
		REG_INV_AXLE    = 3'd1,
		REG_START_X     = 3'd2,
		REG_START_Y     = 3'd3,
		REG_START_HDG   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading;
		logic               saturated;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_word_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load_in;   // capture counts, compute wheel deltas
		logic wheel;     // scale deltas to distances
		logic mix;       // mean, turn, mid heading
		logic rot_init;  // load CORDIC start vector
		logic rot_step;  // one CORDIC iteration
		logic proj;      // distance times cos and sin
		logic commit;    // update pose
		logic latch;     // first item: latch counts only
	} dp_cmd_t;

	typedef struct packed {
		logic primed;
		logic rot_last;
	} dp_sts_t;

	function automatic logic [31:0] atan_entry(input logic [StepW-1:0] i);
		logic [31:0] t;
		case (i)
			5'd0: t = 32'h20000000; 5'd1: t = 32'h12E4051E; 5'd2: t = 32'h09FB385B;
			5'd3: t = 32'h051111D4; 5'd4: t = 32'h028B0D43; 5'd5: t = 32'h0145D7E1;
			5'd6: t = 32'h00A2F61E; 5'd7: t = 32'h00517C55; 5'd8: t = 32'h0028BE53;
			5'd9: t = 32'h00145F2F; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
			5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
			5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
			5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
			5'd27: t = 32'h00000005; 5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
			5'd30: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/differential_drive_odometry_unit.sv -----
// ----------------------------------------------------------------------------
// Differential drive odometry unit
// Dead-reckoning pose tracker for a two-wheel robot.
// ----------------------------------------------------------------------------
// Each input word of absolute encoder counts gives one output word with the
// new pose. A word passes from acceptance through wheel scaling, mixing, CORDIC
// start, the iterative CORDIC that shares one add-shift unit over CORDIC_STEPS
// iterations, projection and commit, and the next word is accepted only once the
// controller is back in idle after the result; the first word after reset only
// latches the counts and returns the current pose. A new word is accepted while the previous result
// still waits in the output register; the pose update then holds until that
// register has been emptied. Register writes are accepted only while idle.
module differential_drive_odometry_unit
	import ddo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_word_t cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic busy, done, in_fire, out_free;
	logic cfg_fire;
	logic out_v_q;

	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_v_q || out_ready;
	assign cfg_ready = !busy;
	assign cfg_fire = cfg_valid && cfg_ready;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (done) out_v_q <= 1'b1;
		else if (out_ready) out_v_q <= 1'b0;
	end
	assign out_valid = out_v_q;

	ddo_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_free, .sts, .cmd, .busy, .done
	);

	ddo_dp u_dp (
		.clk, .arst_n, .cmd, .in_w(in_data), .cfg_we(cfg_fire), .cfg_w(cfg_data),
		.sts, .res(out_data)
	);

	// A result is only produced while busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result without work");
	// Output holds while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");
	// No input accepted while working.
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n) busy |-> !in_ready)
		else $error("input accepted while busy");

endmodule

// ----- rtl/ddo_ctrl.sv -----
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences one word through delta, scaling, mixing, CORDIC and pose update.
// ----------------------------------------------------------------------------
module ddo_ctrl
	import ddo_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    out_free,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_WHEEL = 8'b00000010,
		S_MIX   = 8'b00000100,
		S_INIT  = 8'b00001000,
		S_ROT   = 8'b00010000,
		S_PROJ  = 8'b00100000,
		S_COMM  = 8'b01000000,
		S_LATCH = 8'b10000000
	} state_t;

	state_t state_q, state_d;

	// Next state. The result states hold until the output register is free.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_fire) state_d = sts.primed ? S_WHEEL : S_LATCH;
			S_WHEEL: state_d = S_MIX;
			S_MIX:   state_d = S_INIT;
			S_INIT:  state_d = S_ROT;
			S_ROT:   if (sts.rot_last) state_d = S_PROJ;
			S_PROJ:  state_d = S_COMM;
			S_COMM:  if (out_free) state_d = S_IDLE;
			S_LATCH: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Commands decode from the state, the input handshake and the output register.
	always_comb begin
		cmd = '0;
		cmd.load_in  = in_fire;
		cmd.wheel    = (state_q == S_WHEEL);
		cmd.mix      = (state_q == S_MIX);
		cmd.rot_init = (state_q == S_INIT);
		cmd.rot_step = (state_q == S_ROT);
		cmd.proj     = (state_q == S_PROJ);
		cmd.commit   = (state_q == S_COMM) && out_free;
		cmd.latch    = (state_q == S_LATCH) && out_free;
	end

	assign busy = (state_q != S_IDLE);
	assign done = cmd.commit || cmd.latch;

endmodule

// ----- rtl/ddo_dp.sv -----
// ----------------------------------------------------------------------------
// Odometry datapath
// Pose and count registers, configuration registers, wheel scaling,
// heading mix, iterative CORDIC rotation and saturating pose update.
// ----------------------------------------------------------------------------
module ddo_dp
	import ddo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	input  in_word_t  in_w,
	input  logic      cfg_we,
	input  cfg_word_t cfg_w,
	output dp_sts_t   sts,
	output out_word_t res
);

	logic [23:0] enc_scale_q;
	logic [31:0] inv_axle_q;
	logic [31:0] prev_l_q, prev_r_q;
	logic        primed_q;
	logic signed [31:0] pose_x_q, pose_y_q;
	logic [31:0] pose_h_q;

	logic signed [31:0] dtl_q, dtr_q;
	logic signed [56:0] dl_q, dr_q;
	logic signed [34:0] dc_q;
	logic [31:0] turn_q, mid_q;
	logic        sat_q, fold_q;
	logic signed [34:0] cx_q, cy_q;
	logic signed [32:0] z_q;
	logic [StepW-1:0] step_q;
	logic signed [69:0] px_q, py_q;

	// Wheel distance, rounded.
	logic signed [56:0] dl_n, dr_n;
	assign dl_n = ($signed(dtl_q) * $signed({1'b0, enc_scale_q}) + 57'sd128) >>> 8;
	assign dr_n = ($signed(dtr_q) * $signed({1'b0, enc_scale_q}) + 57'sd128) >>> 8;

	// Mean distance, clamp, turn and mid heading.
	logic signed [57:0] dsum, ddif;
	logic signed [56:0] dc_full;
	logic [63:0] ddif_x;
	logic [63:0] p_lo;
	logic [31:0] p_hi;
	logic [63:0] p_w;
	logic [31:0] half_w;
	assign dsum = 58'(dl_q) + 58'(dr_q);
	assign ddif = 58'(dr_q) - 58'(dl_q);
	assign dc_full = 57'(dsum >>> 1);
	// Heading product from two 32 by 32 partial products; only the low 64 bits count.
	assign ddif_x = 64'(ddif);
	assign p_lo = 64'(ddif_x[31:0]) * 64'(inv_axle_q);
	assign p_hi = ddif_x[63:32] * inv_axle_q;
	assign p_w = p_lo + {p_hi, 32'd0};
	assign half_w = 32'((p_w + 64'h10000) >> 17);

	// CORDIC iteration.
	logic signed [34:0] xs, ys;
	logic [31:0] at;
	assign xs = cx_q >>> step_q;
	assign ys = cy_q >>> step_q;
	assign at = atan_entry(step_q);

	// Pose update with saturation.
	logic signed [39:0] stx, sty, nx, ny;
	assign stx = 40'((px_q + 70'sd536870912) >>> 30);
	assign sty = 40'((py_q + 70'sd536870912) >>> 30);
	assign nx = 40'(pose_x_q) + stx;
	assign ny = 40'(pose_y_q) + sty;
	logic x_hi, x_lo, y_hi, y_lo;
	assign x_hi = nx > 40'sd2147483647;
	assign x_lo = nx < -40'sd2147483648;
	assign y_hi = ny > 40'sd2147483647;
	assign y_lo = ny < -40'sd2147483648;

	assign sts.primed = primed_q;
	assign sts.rot_last = (step_q == StepW'(CORDIC_STEPS - 1));

	// Control and pose registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_scale_q <= 24'd65536;
			inv_axle_q  <= 32'd1048576;
			prev_l_q <= '0;
			prev_r_q <= '0;
			primed_q <= 1'b0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
			res <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_w.index)
					REG_ENC_SCALE: enc_scale_q <= cfg_w.data[23:0];
					REG_INV_AXLE:  inv_axle_q <= cfg_w.data;
					REG_START_X:   pose_x_q <= $signed(cfg_w.data);
					REG_START_Y:   pose_y_q <= $signed(cfg_w.data);
					REG_START_HDG: pose_h_q <= cfg_w.data;
					default: ;
				endcase
			end
			if (cmd.load_in) begin
				prev_l_q <= in_w.left_count;
				prev_r_q <= in_w.right_count;
				primed_q <= 1'b1;
			end
			if (cmd.latch) res <= '{pose_x_q, pose_y_q, pose_h_q, 1'b0};
			if (cmd.commit) begin
				pose_x_q <= x_hi ? 32'sh7FFFFFFF : x_lo ? 32'sh80000000 : nx[31:0];
				pose_y_q <= y_hi ? 32'sh7FFFFFFF : y_lo ? 32'sh80000000 : ny[31:0];
				pose_h_q <= pose_h_q + turn_q;
				res.pos_x <= x_hi ? 32'sh7FFFFFFF : x_lo ? 32'sh80000000 : nx[31:0];
				res.pos_y <= y_hi ? 32'sh7FFFFFFF : y_lo ? 32'sh80000000 : ny[31:0];
				res.heading <= pose_h_q + turn_q;
				res.saturated <= sat_q | x_hi | x_lo | y_hi | y_lo;
			end
		end
	end

	// Arithmetic work registers.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dtl_q <= in_w.left_count - $signed(prev_l_q);
			dtr_q <= in_w.right_count - $signed(prev_r_q);
		end
		if (cmd.wheel) begin
			dl_q <= dl_n;
			dr_q <= dr_n;
		end
		if (cmd.mix) begin
			turn_q <= 32'((p_w + 64'h8000) >> 16);
			mid_q  <= pose_h_q + half_w;
			if (dc_full > 57'sh100000000) begin
				dc_q <= 35'sh100000000; sat_q <= 1'b1;
			end else if (dc_full < -57'sh100000000) begin
				dc_q <= -35'sh100000000; sat_q <= 1'b1;
			end else begin
				dc_q <= 35'(dc_full); sat_q <= 1'b0;
			end
		end
		if (cmd.rot_init) begin
			fold_q <= mid_q[31] ^ mid_q[30];
			z_q <= 33'($signed({mid_q[31] ^ (mid_q[31] ^ mid_q[30]), mid_q[30:0]}));
			cx_q <= CordicGain;
			cy_q <= '0;
			step_q <= '0;
		end
		if (cmd.rot_step) begin
			if (!z_q[32]) begin
				cx_q <= cx_q - ys; cy_q <= cy_q + xs; z_q <= z_q - $signed({1'b0, at});
			end else begin
				cx_q <= cx_q + ys; cy_q <= cy_q - xs; z_q <= z_q + $signed({1'b0, at});
			end
			step_q <= step_q + 1'b1;
		end
		if (cmd.proj) begin
			px_q <= dc_q * (fold_q ? -cx_q : cx_q);
			py_q <= dc_q * (fold_q ? -cy_q : cy_q);
		end
	end

endmodule
